// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define TDIM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TDIM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TDIM_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDIM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/tdim_pkg.sv =====
// ----------------------------------------------------------------------------
// tdim_pkg
// Shared widths, codes, reset values and types of the triac dimmer.
// ----------------------------------------------------------------------------
package tdim_pkg;

    localparam int unsigned TRIG_W      = 16;
    localparam int unsigned DEB_W       = 8;
    localparam int unsigned PER_W       = 16;
    localparam int unsigned GAIN_W      = 24;
    localparam int unsigned POS_W       = PER_W + 1;
    localparam int unsigned TRI_W       = PER_W;
    localparam int unsigned PROD_W      = TRI_W + GAIN_W;
    localparam int unsigned Q_SHIFT     = 16;
    localparam int unsigned SCALED_W    = PROD_W - Q_SHIFT;
    localparam int unsigned OUT_DELAY_W = 17;
    localparam int unsigned PHASE_W     = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_W       = 24;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_DATA_W  = 24;

    localparam logic [PHASE_W-1:0] PH_ARMED = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CHECK = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DELAY = 2'd2;
    localparam logic [PHASE_W-1:0] PH_FIRE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd3;

    localparam logic [TRIG_W-1:0] TRIGGER_RST  = 16'd800;
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 8'd50;
    localparam logic [PER_W-1:0]  PERIOD_RST   = 16'd10000;
    localparam logic [GAIN_W-1:0] GAIN_RST     = 24'd413401;

    localparam logic KIND_TIMER = 1'b0;

    typedef struct packed {
        logic [TRIG_W-1:0] trigger_ticks;
        logic [DEB_W-1:0]  debounce_samples;
    } t_zc_cfg;

    typedef struct packed {
        logic [PER_W-1:0]  period;
        logic [GAIN_W-1:0] gain;
    } t_ramp_cfg;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               marker;
    } t_zc_stat;

endpackage

// ===== sv/tdim_ramp.sv =====
// ----------------------------------------------------------------------------
// tdim_ramp
// Triangle brightness ramp and Q16 scaling of the firing delay.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdim_ramp
    import tdim_pkg::*;
#(
    parameter int unsigned DELAY_WIDTH = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_ramp_cfg              i_cfg,
    output logic [DELAY_WIDTH-1:0] o_delay,
    output logic [DELAY_WIDTH-1:0] o_delay_nxt
);

    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    logic [DELAY_WIDTH-1:0] r_delay;
    logic [DELAY_WIDTH-1:0] n_delay;

    logic [POS_W-1:0]       w_two;
    logic [POS_W-1:0]       w_diff;
    logic                   w_wrap;
    logic                   w_rising;
    logic [TRI_W-1:0]       w_tri;
    logic [PROD_W-1:0]      w_prod;
    logic [SCALED_W-1:0]    w_scaled;
    logic [DELAY_WIDTH-1:0] w_sat;

    assign w_two    = {i_cfg.period, 1'b0};
    assign w_diff   = w_two - r_pos;
    assign w_wrap   = r_pos >= w_two;
    assign w_rising = r_pos < {1'b0, i_cfg.period};
    assign w_tri    = w_rising ? r_pos[TRI_W-1:0] : w_diff[TRI_W-1:0];
    assign w_prod   = w_tri * i_cfg.gain;
    assign w_scaled = w_prod[PROD_W-1:Q_SHIFT];

    generate
        if (DELAY_WIDTH >= SCALED_W) begin : g_nosat
            assign w_sat = DELAY_WIDTH'(w_scaled);
        end else begin : g_sat
            assign w_sat = (|w_scaled[SCALED_W-1:DELAY_WIDTH]) ? '1
                                                               : w_scaled[DELAY_WIDTH-1:0];
        end
    endgenerate

    always_comb begin
        n_pos   = r_pos;
        n_delay = r_delay;
        if (i_en) begin
            if (w_wrap) begin
                n_pos = POS_W'(1);
            end else begin
                n_pos   = r_pos + POS_W'(1);
                n_delay = w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_delay <= '0;
        end else begin
            r_pos   <= n_pos;
            r_delay <= n_delay;
        end
    end

    assign o_delay     = r_delay;
    assign o_delay_nxt = n_delay;

    `TDIM_ASSERT(a_ramp_wrap, i_clk, i_rst_n, i_en && w_wrap |=> r_pos == POS_W'(1), "ramp did not restart")

endmodule

// ===== sv/tdim_zc.sv =====
// ----------------------------------------------------------------------------
// tdim_zc
// Zero-cross debounce, firing delay countdown and gate pulse sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdim_zc
    import tdim_pkg::*;
#(
    parameter int unsigned DELAY_WIDTH = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_lvl,
    input  t_zc_cfg                i_cfg,
    input  logic [DELAY_WIDTH-1:0] i_firing_delay,
    output t_zc_stat               o_stat_nxt
);

    localparam int unsigned CNT_W = (DELAY_WIDTH > TRIG_W) ? DELAY_WIDTH : TRIG_W;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic               r_ref;
    logic               n_ref;
    logic [DEB_W-1:0]   r_stable;
    logic [DEB_W-1:0]   n_stable;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_marker;
    logic               n_marker;

    logic [DEB_W-1:0]   w_stable_inc;
    logic               w_cnt_zero;
    logic               w_cnt_last;

    assign w_stable_inc = r_stable + DEB_W'(1);
    assign w_cnt_zero   = r_cnt == '0;
    assign w_cnt_last   = r_cnt[CNT_W-1:1] == '0;

    always_comb begin
        n_phase  = r_phase;
        n_ref    = r_ref;
        n_stable = r_stable;
        n_cnt    = r_cnt;
        n_marker = r_marker;
        if (i_en) begin
            unique case (r_phase)
                PH_ARMED: begin
                    if (i_lvl != r_ref) begin
                        n_ref    = i_lvl;
                        n_stable = '0;
                        n_phase  = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (i_lvl != r_ref) begin
                        n_ref   = i_lvl;
                        n_phase = PH_ARMED;
                    end else begin
                        n_stable = w_stable_inc;
                        if (w_stable_inc >= i_cfg.debounce_samples) begin
                            n_marker = ~r_marker;
                            n_cnt    = CNT_W'(i_firing_delay);
                            n_phase  = PH_DELAY;
                        end
                    end
                end
                PH_DELAY: begin
                    if (w_cnt_zero) begin
                        n_cnt   = CNT_W'(i_cfg.trigger_ticks);
                        n_phase = PH_FIRE;
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
                PH_FIRE: begin
                    if (w_cnt_last) begin
                        n_cnt   = '0;
                        n_ref   = i_lvl;
                        n_phase = PH_ARMED;
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_ARMED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ARMED;
            r_ref    <= 1'b0;
            r_stable <= '0;
            r_cnt    <= '0;
            r_marker <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_ref    <= n_ref;
            r_stable <= n_stable;
            r_cnt    <= n_cnt;
            r_marker <= n_marker;
        end
    end

    assign o_stat_nxt.phase  = n_phase;
    assign o_stat_nxt.marker = n_marker;

    // glitch during debounce drops back to armed
    `TDIM_ASSERT(a_zc_glitch, i_clk, i_rst_n, i_en && r_phase == PH_CHECK && i_lvl != r_ref |=> r_phase == PH_ARMED, "debounce glitch not rejected")
    // marker moves only on an accepted crossing
    `TDIM_ASSERT(a_zc_marker, i_clk, i_rst_n, $past(i_rst_n) && r_marker != $past(r_marker) |-> r_phase == PH_DELAY, "marker toggled outside crossing accept")

endmodule

// ===== sv/triac_phase_angle_dimmer.sv =====
// ----------------------------------------------------------------------------
// triac_phase_angle_dimmer
// Pipeline: a taken request is held in the input register, then its result is
//   loaded into the result register, which drives the master side.
// Throughput: one request per cycle unless the master side stalls; the ramp
//   multiply and the phase update fit in the single stage between the two registers.
// Reset: synchronous, active low; clears the phase state, ramp and the valid
//   flags of both pipeline registers and restores the configuration defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triac_phase_angle_dimmer
    import tdim_pkg::*;
#(
    parameter int unsigned DELAY_WIDTH = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] zero_cross_level
    input  logic [0:0]            s_axis_tuser,   // [0] kind

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] triac_gate, [1] crossing_marker,
                                                  // [18:2] current_delay, [20:19] phase_code
);

    logic [TRIG_W-1:0]      r_trigger;
    logic [DEB_W-1:0]       r_debounce;
    logic [PER_W-1:0]       r_period;
    logic [GAIN_W-1:0]      r_gain;

    logic                   r_in_valid;
    logic                   r_in_kind;
    logic                   r_in_lvl;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic                   w_advance;
    logic                   w_timer_en;
    logic                   w_ramp_en;
    t_zc_cfg                w_zc_cfg;
    t_ramp_cfg              w_ramp_cfg;
    t_zc_stat               w_stat_nxt;
    logic [DELAY_WIDTH-1:0] w_delay;
    logic [DELAY_WIDTH-1:0] w_delay_nxt;
    logic [OUT_DELAY_W-1:0] w_delay_out;
    logic                   w_gate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger  <= TRIGGER_RST;
            r_debounce <= DEBOUNCE_RST;
            r_period   <= PERIOD_RST;
            r_gain     <= GAIN_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TRIGGER:  r_trigger  <= i_cfg_data[TRIG_W-1:0];
                CFG_DEBOUNCE: r_debounce <= i_cfg_data[DEB_W-1:0];
                CFG_PERIOD:   r_period   <= i_cfg_data[PER_W-1:0];
                CFG_GAIN:     r_gain     <= i_cfg_data[GAIN_W-1:0];
                default:      r_gain     <= r_gain;
            endcase
        end
    end

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_timer_en    = w_advance && (r_in_kind == KIND_TIMER);
    assign w_ramp_en     = w_advance && (r_in_kind != KIND_TIMER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser[0];
            r_in_lvl  <= s_axis_tdata[0];
        end
    end

    assign w_zc_cfg.trigger_ticks    = r_trigger;
    assign w_zc_cfg.debounce_samples = r_debounce;
    assign w_ramp_cfg.period         = r_period;
    assign w_ramp_cfg.gain           = r_gain;

    tdim_ramp #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_ramp_en),
        .i_cfg       (w_ramp_cfg),
        .o_delay     (w_delay),
        .o_delay_nxt (w_delay_nxt)
    );

    tdim_zc #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_zc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_timer_en),
        .i_lvl          (r_in_lvl),
        .i_cfg          (w_zc_cfg),
        .i_firing_delay (w_delay),
        .o_stat_nxt     (w_stat_nxt)
    );

    assign w_delay_out = OUT_DELAY_W'(w_delay_nxt);
    assign w_gate      = w_stat_nxt.phase == PH_FIRE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= OUT_DATA_W'({w_stat_nxt.phase, w_delay_out,
                                       w_stat_nxt.marker, w_gate});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // input side stalls only with both registers full and the sink stalled
    `TDIM_ASSERT(a_top_stall, i_clk, i_rst_n, !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready, "request refused without backpressure")

endmodule
